[hw/rtl/rfp_pkg.sv]
`timescale 1ns / 1ps
package rfp_pkg;

  localparam int RFP_WIDTH_W        = 13;
  localparam int RFP_COLOR_W        = 8;
  localparam int RFP_BYTE_W         = 8;
  localparam int RFP_MAX_ROW_PIXELS = 8144;
  localparam int RFP_QUEUE_DEPTH    = 4;
  localparam int RFP_CFG_INDEX_W    = 2;
  localparam int RFP_CFG_DATA_W     = 13;

  localparam logic [RFP_CFG_INDEX_W-1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [RFP_CFG_INDEX_W-1:0] REG_MATCH_COLOR = 2'd1;

  localparam logic [RFP_WIDTH_W-1:0] ROW_WIDTH_RESET   = 13'd200;
  localparam logic [RFP_COLOR_W-1:0] MATCH_COLOR_RESET = 8'd0;

  localparam logic [RFP_BYTE_W-1:0] HDR_K = 8'h4B;
  localparam logic [RFP_BYTE_W-1:0] HDR_D = 8'h44;
  localparam logic [RFP_BYTE_W-1:0] HDR_B = 8'h42;

  // Byte slots of one queued job, in emission order.
  typedef enum logic [2:0] {
    SLOT_K,
    SLOT_D,
    SLOT_B,
    SLOT_WHI,
    SLOT_WLO,
    SLOT_DATA,
    SLOT_SUM
  } rfp_slot_t;

  localparam int RFP_SLOTS = 7;

  typedef struct packed {
    logic                   hdr;
    logic                   has_data;
    logic                   last;
    logic [RFP_WIDTH_W-1:0] width;
    logic [RFP_BYTE_W-1:0]  data;
    logic [RFP_BYTE_W-1:0]  csum;
  } rfp_job_t;

endpackage

[hw/rtl/rfp_if.sv]
`timescale 1ns / 1ps
interface rfp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_index;
  logic       inverse;
  modport source(output valid, pixel_index, inverse, input ready);
  modport sink(input valid, pixel_index, inverse, output ready);
endinterface

interface rfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source(output valid, frame_byte, frame_end, input ready);
  modport sink(input valid, frame_byte, frame_end, output ready);
endinterface

interface rfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [12:0] wdata;
  modport source(output valid, reg_index, wdata, input ready);
  modport sink(input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/pattern_row_frame_packer_top.sv]
`timescale 1ns / 1ps
// Row frame packer: one indexed pixel per word on in_ch, framed bytes on out_ch.
// A row's first pixel yields the header 'K','D','B', width high, width low;
// each pixel adds one bit (MSB first), a data byte leaves every eighth pixel
// and at the row's last pixel (zero padded), then the checksum byte with
// frame_end set. Up to 7 output words per pixel.
// cfg_ch writes row_width (index 0) and match_color (index 1); always ready.
// Write it only while no frame is in flight.
// With the queue empty and out_ch free, the first byte caused by a pixel
// passes the queue write and then the output register before it is valid.
// Throughput: one pixel per cycle; out_ch drains one byte per cycle
// from a job queue of QUEUE_DEPTH entries, so in_ch only stalls when header,
// data and checksum bursts outrun the output (a row of 7 or more pixels needs
// at most one byte per pixel).
// When out_ch stalls, the output register holds its word, the queue fills and
// in_ready drops once it is full.
// Reset: row position, partial byte and checksum cleared, queue emptied,
// row_width = 200, match_color = 0. No warm-up after reset.
module pattern_row_frame_packer_top
  import rfp_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = RFP_MAX_ROW_PIXELS,
  parameter int QUEUE_DEPTH    = RFP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rfp_pix_if.sink     in_ch,
  rfp_byte_if.source  out_ch,
  rfp_cfg_if.sink     cfg_ch
);

  logic [RFP_WIDTH_W-1:0] row_width_r;
  logic [RFP_COLOR_W-1:0] match_color_r;

  logic     q_full;
  logic     q_push;
  rfp_job_t q_job;
  logic     q_pop;
  logic     q_valid;
  rfp_job_t q_head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RESET;
      match_color_r <= MATCH_COLOR_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_ROW_WIDTH:   row_width_r   <= cfg_ch.wdata[RFP_WIDTH_W-1:0];
        REG_MATCH_COLOR: match_color_r <= cfg_ch.wdata[RFP_COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  rfp_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .pixel_index (in_ch.pixel_index),
    .inverse     (in_ch.inverse),
    .row_width   (row_width_r),
    .match_color (match_color_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  rfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  rfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full || q_pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job queue underflow");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_end_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_head.hdr || q_head.has_data))
    else $error("queued job carries no byte");

endmodule

[hw/rtl/rfp_front.sv]
`timescale 1ns / 1ps
module rfp_front
  import rfp_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = RFP_MAX_ROW_PIXELS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             pixel_index,
  input  logic                   inverse,
  input  logic [RFP_WIDTH_W-1:0] row_width,
  input  logic [RFP_COLOR_W-1:0] match_color,
  input  logic                   q_full,
  output logic                   q_push,
  output rfp_job_t               q_job
);

  logic [RFP_WIDTH_W-1:0] pos_r, pos_nxt;
  logic [RFP_BYTE_W-1:0]  acc_r, acc_nxt;
  logic [RFP_BYTE_W-1:0]  sum_r, sum_nxt;

  logic                   accept;
  logic                   hdr;
  logic                   bit_set;
  logic                   emit;
  logic                   last;
  logic [RFP_WIDTH_W-1:0] width;
  logic [RFP_BYTE_W-1:0]  whi, wlo;
  logic [RFP_BYTE_W-1:0]  hdr_sum;
  logic [RFP_BYTE_W-1:0]  acc_new;
  logic [RFP_BYTE_W-1:0]  sum_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (row_width == '0) begin
      width = RFP_WIDTH_W'(1);
    end else if (32'(row_width) > 32'(MAX_ROW_PIXELS)) begin
      width = RFP_WIDTH_W'(MAX_ROW_PIXELS);
    end else begin
      width = row_width;
    end
  end

  assign hdr     = (pos_r == '0);
  assign whi     = RFP_BYTE_W'(width >> 8);
  assign wlo     = width[7:0];
  assign hdr_sum = hdr ? (HDR_K + HDR_D + HDR_B + whi + wlo) : 8'd0;
  assign bit_set = (pixel_index == match_color) != inverse;
  assign acc_new = (hdr ? 8'd0 : acc_r) | (bit_set ? (8'h80 >> pos_r[2:0]) : 8'd0);
  assign last    = ({1'b0, pos_r} + 14'd1) >= {1'b0, width};
  assign emit    = (pos_r[2:0] == 3'd7) || last;
  assign sum_new = (hdr ? 8'd0 : sum_r) + hdr_sum + (emit ? acc_new : 8'd0);

  always_comb begin
    if (last) begin
      pos_nxt = '0;
      acc_nxt = '0;
      sum_nxt = '0;
    end else begin
      pos_nxt = pos_r + RFP_WIDTH_W'(1);
      acc_nxt = emit ? 8'd0 : acc_new;
      sum_nxt = sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      sum_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign q_push         = accept && (hdr || emit);
  assign q_job.hdr      = hdr;
  assign q_job.has_data = emit;
  assign q_job.last     = last;
  assign q_job.width    = width;
  assign q_job.data     = acc_new;
  assign q_job.csum     = sum_new;

endmodule

[hw/rtl/rfp_queue.sv]
`timescale 1ns / 1ps
module rfp_queue
  import rfp_pkg::*;
#(
  parameter int DEPTH = RFP_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rfp_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output rfp_job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rfp_job_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hw/rtl/rfp_back.sv]
`timescale 1ns / 1ps
module rfp_back
  import rfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  rfp_job_t          head_job,
  output logic              pop,
  rfp_byte_if.source        out_ch
);

  logic [2:0]            slot_r, slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RFP_BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                  out_end_r, out_end_nxt;

  logic                  load;
  logic [RFP_SLOTS-1:0]  mask;
  logic [RFP_SLOTS-1:0]  avail;
  logic [RFP_SLOTS-1:0]  rest;
  rfp_slot_t             cur;
  logic [RFP_BYTE_W-1:0] cur_byte;

  assign load  = !out_valid_r || out_ch.ready;
  assign mask  = {head_job.last, head_job.has_data, {5{head_job.hdr}}};
  assign avail = mask & (7'h7F << slot_r);

  always_comb begin
    cur = SLOT_SUM;
    for (int i = RFP_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        cur = rfp_slot_t'(3'(i));
      end
    end
  end

  assign rest = avail & ~(7'd1 << cur);

  always_comb begin
    case (cur)
      SLOT_K:    cur_byte = HDR_K;
      SLOT_D:    cur_byte = HDR_D;
      SLOT_B:    cur_byte = HDR_B;
      SLOT_WHI:  cur_byte = RFP_BYTE_W'(head_job.width >> 8);
      SLOT_WLO:  cur_byte = head_job.width[7:0];
      SLOT_DATA: cur_byte = head_job.data;
      SLOT_SUM:  cur_byte = head_job.csum;
      default:   cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_byte_nxt = cur_byte;
        out_end_nxt  = (cur == SLOT_SUM);
        if (rest == '0) begin
          pop      = 1'b1;
          slot_nxt = '0;
        end else begin
          slot_nxt = 3'(cur) + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.frame_end  = out_end_r;

endmodule

[dv/pattern_row_frame_packer_top_tb.sv]
`timescale 1ns / 1ps
module pattern_row_frame_packer_top_tb;
  import rfp_pkg::*;

  localparam logic [RFP_CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [RFP_CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 16;
  localparam int RANDOM_WORDS = 150;

  typedef struct packed {
    logic [7:0] index;
    logic       inverse;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_word_t;

  typedef enum logic [1:0] {INV_OFF, INV_ON, INV_MIX} inv_mode_t;

  logic clk;
  logic rst_n;

  rfp_pix_if  in_if();
  rfp_byte_if out_if();
  rfp_cfg_if  cfg_if();

  pattern_row_frame_packer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pixel_word_t pixel_q[$];
  frame_word_t frame_q[$];
  pixel_word_t next_pix;
  frame_word_t seen_word;

  logic [RFP_WIDTH_W-1:0] row_width_m;
  logic [7:0]             color_m;
  logic [RFP_WIDTH_W-1:0] pos_m;
  logic [7:0]             acc_m;
  logic [7:0]             sum_m;

  logic gaps_on;
  logic hold_req;
  logic hold_seen;
  int   hold_left;
  int   error_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic void put_summed(input logic [7:0] b);
    sum_m = sum_m + b;
    frame_q.push_back('{frame_byte: b, frame_end: 1'b0});
  endfunction

  function automatic void pack_pixel(input logic [7:0] pix, input logic inv);
    logic [15:0] w;
    logic        last;
    if (row_width_m == 0) w = 16'd1;
    else if (row_width_m > RFP_MAX_ROW_PIXELS) w = 16'(RFP_MAX_ROW_PIXELS);
    else w = 16'(row_width_m);
    if (pos_m == 0) begin
      sum_m = 8'd0;
      acc_m = 8'd0;
      put_summed(HDR_K);
      put_summed(HDR_D);
      put_summed(HDR_B);
      put_summed(w[15:8]);
      put_summed(w[7:0]);
    end
    if ((pix == color_m) != inv) acc_m = acc_m | (8'h80 >> pos_m[2:0]);
    last = (int'(pos_m) + 1 >= int'(w));
    if (pos_m[2:0] == 3'd7 || last) begin
      put_summed(acc_m);
      acc_m = 8'd0;
    end
    if (last) begin
      frame_q.push_back('{frame_byte: sum_m, frame_end: 1'b1});
      pos_m = '0;
      sum_m = 8'd0;
      acc_m = 8'd0;
    end else begin
      pos_m = pos_m + 1'b1;
    end
  endfunction

  // register shadow
  always @(posedge clk) begin
    if (!rst_n) begin
      row_width_m <= ROW_WIDTH_RESET;
      color_m     <= MATCH_COLOR_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.reg_index)
        REG_ROW_WIDTH: begin
          row_width_m <= cfg_if.wdata;
        end
        REG_MATCH_COLOR: begin
          color_m <= cfg_if.wdata[7:0];
        end
        default: ;
      endcase
    end
  end

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      pos_m = '0;
      acc_m = 8'd0;
      sum_m = 8'd0;
    end else begin
      if (in_if.valid && in_if.ready) pack_pixel(in_if.pixel_index, in_if.inverse);
      if (!in_if.valid || in_if.ready) begin
        if (pixel_q.size() != 0 && !(gaps_on && $urandom_range(99) < 28)) begin
          next_pix = pixel_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.pixel_index <= next_pix.index;
          in_if.inverse     <= next_pix.inverse;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end
  end

  // byte monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (frame_q.size() == 0) begin
          flag_error($sformatf("unexpected word %02h end=%0b",
                               out_if.frame_byte, out_if.frame_end));
        end else begin
          seen_word = frame_q.pop_front();
          if (out_if.frame_byte !== seen_word.frame_byte)
            flag_error($sformatf("frame_byte %02h, want %02h",
                                 out_if.frame_byte, seen_word.frame_byte));
          if (out_if.frame_end !== seen_word.frame_end)
            flag_error($sformatf("frame_end %0b, want %0b on byte %02h",
                                 out_if.frame_end, seen_word.frame_end,
                                 seen_word.frame_byte));
        end
      end
      out_if.ready <= (hold_left == 0) && !(gaps_on && $urandom_range(99) < 28);
    end
  end

  task automatic write_reg(input logic [RFP_CFG_INDEX_W-1:0] idx,
                           input logic [RFP_CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_pixel(input logic [7:0] idx, input logic inv);
    pixel_q.push_back('{index: idx, inverse: inv});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_if.valid || frame_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int        n_rand;
    int        phase;
    int        n;
    int        w;
    int        sel;
    logic [7:0] color;
    logic [7:0] pix;
    logic       inv;
    inv_mode_t  im;

    rst_n             = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = REG_ROW_WIDTH;
    cfg_if.wdata      = '0;
    gaps_on           = 1'b1;
    hold_req          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, then shrink the width under a partial row
    @(negedge clk);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h00, 1'b1);
    wait_idle();
    write_reg(REG_ROW_WIDTH, 13'd2);
    @(negedge clk);
    push_pixel(8'hFF, 1'b1);
    wait_idle();

    // two data bytes, second one padded
    write_reg(REG_ROW_WIDTH, 13'd10);
    write_reg(REG_MATCH_COLOR, 13'h1FA5);
    @(negedge clk);
    push_pixel(8'hA5, 1'b0);
    push_pixel(8'h5A, 1'b0);
    push_pixel(8'hA5, 1'b1);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'hA5, 1'b0);
    push_pixel(8'hA5, 1'b0);
    push_pixel(8'h7E, 1'b1);
    push_pixel(8'hA5, 1'b0);
    push_pixel(8'h81, 1'b0);
    wait_idle();

    // zero width acts as one pixel per row; spare indexes are ignored
    write_reg(REG_ROW_WIDTH, 13'd0);
    write_reg(REG_MATCH_COLOR, 13'h00FF);
    write_reg(REG_SPARE_A, 13'h1FFF);
    write_reg(REG_SPARE_B, 13'h0AAA);
    @(negedge clk);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b1);
    wait_idle();

    // oversize width clamps in the header, then cut the row short
    write_reg(REG_ROW_WIDTH, 13'h1FFF);
    @(negedge clk);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h7F, 1'b0);
    wait_idle();
    write_reg(REG_ROW_WIDTH, 13'd1);
    @(negedge clk);
    push_pixel(8'hFF, 1'b0);
    wait_idle();

    n_rand = 0;
    phase  = 0;
    while (n_rand < RANDOM_WORDS) begin
      sel = $urandom_range(99);
      if (phase == 0) w = $urandom_range(0, 2);
      else if (sel < 70) w = $urandom_range(1, 24);
      else if (sel < 88) w = $urandom_range(25, 80);
      else begin
        case ($urandom_range(4))
          0: w = 0;
          1: w = 1;
          2: w = 8;
          3: w = RFP_MAX_ROW_PIXELS;
          default: w = 8191;
        endcase
      end
      color = 8'($urandom);
      if ($urandom_range(1)) begin
        write_reg(REG_MATCH_COLOR, {5'($urandom_range(31)), color});
        write_reg(REG_ROW_WIDTH, 13'(w));
      end else begin
        write_reg(REG_ROW_WIDTH, 13'(w));
        write_reg(REG_MATCH_COLOR, {5'($urandom_range(31)), color});
      end
      n  = (phase == 0 || phase == 3) ? 40 : $urandom_range(4, 30);
      im = inv_mode_t'($urandom_range(2));
      @(negedge clk);
      gaps_on = (phase != 3);
      if (phase == 0) hold_req = ~hold_req;
      repeat (n) begin
        pix = ($urandom_range(99) < 40) ? color : 8'($urandom);
        case (im)
          INV_OFF: inv = 1'b0;
          INV_ON:  inv = 1'b1;
          default: inv = 1'($urandom_range(1));
        endcase
        push_pixel(pix, inv);
      end
      n_rand += n;
      phase++;
      wait_idle();
      gaps_on = 1'b1;
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
